// ----- rtl/core/gbe_pkg.sv -----
// ----------------------------------------------------------------------------
// gbe_pkg
// Shared types and constants for the gyro bias estimator: payload structs,
// register indexes, register reset values and lane status.
// ----------------------------------------------------------------------------
package gbe_pkg;

  localparam int unsigned NumAxes   = 3;
  localparam int unsigned SampleW   = 32;
  localparam int unsigned AccW      = 48;
  localparam int unsigned AccFracW  = 16;  // Q16.32 to Q16.16
  localparam int unsigned ThreshW   = 31;
  localparam int unsigned TimeoutW  = 16;
  localparam int unsigned CoefW     = 24;
  localparam int unsigned ProdShift = 8;   // Q16.40 to Q16.32
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 31;

  localparam logic [CfgIdxW-1:0] RegThreshold = 2'd0;
  localparam logic [CfgIdxW-1:0] RegTimeout   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegCoef      = 2'd2;

  localparam logic [ThreshW-1:0]  ThresholdRst = 31'd196608;
  localparam logic [TimeoutW-1:0] TimeoutRst   = 16'd300;
  localparam logic [CoefW-1:0]    CoefRst      = 24'd21083;

  typedef struct packed {
    logic signed [SampleW-1:0] gyro_x;
    logic signed [SampleW-1:0] gyro_y;
    logic signed [SampleW-1:0] gyro_z;
  } in_t;

  typedef struct packed {
    logic signed [SampleW-1:0] corrected_x;
    logic signed [SampleW-1:0] corrected_y;
    logic signed [SampleW-1:0] corrected_z;
    logic signed [SampleW-1:0] offset_out_x;
    logic signed [SampleW-1:0] offset_out_y;
    logic signed [SampleW-1:0] offset_out_z;
    logic                      is_stationary;
    logic                      is_adapting;
  } out_t;

  typedef struct packed {
    logic still;
    logic adapt;
  } status_t;

endpackage

// ----- rtl/core/gbe_lane.sv -----
// ----------------------------------------------------------------------------
// gbe_lane
// One axis: subtracts the Q16.16 offset, saturates, checks the magnitude
// against the threshold and accumulates the scaled correction into the
// Q16.32 offset when the merge stage grants adaptation.
// ----------------------------------------------------------------------------
module gbe_lane (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 take_i,
  input  logic signed [gbe_pkg::SampleW-1:0]   gyro_i,
  input  logic        [gbe_pkg::ThreshW-1:0]   threshold_i,
  input  logic        [gbe_pkg::CoefW-1:0]     coef_i,
  input  gbe_pkg::status_t                     status_i,
  output logic                                 within_o,
  output logic signed [gbe_pkg::SampleW-1:0]   corrected_o,
  output logic signed [gbe_pkg::SampleW-1:0]   offset_o
);

  localparam int unsigned SW = gbe_pkg::SampleW;
  localparam int unsigned AW = gbe_pkg::AccW;
  localparam int unsigned PW = SW + gbe_pkg::CoefW + 1;

  logic signed [AW-1:0] acc_q, acc_d;
  logic signed [SW-1:0] off;
  logic signed [SW:0]   diff;
  logic signed [SW-1:0] corr;
  logic        [SW-1:0] mag;
  logic signed [PW-1:0] prod;
  logic signed [AW-1:0] inc;
  logic signed [AW:0]   sum;
  logic signed [AW-1:0] sum_sat;

  assign off  = acc_q[AW-1:gbe_pkg::AccFracW];
  assign diff = {gyro_i[SW-1], gyro_i} - {off[SW-1], off};

  always_comb begin
    if (diff[SW] != diff[SW-1]) begin
      corr = diff[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end else begin
      corr = diff[SW-1:0];
    end
  end

  // most negative value gives 2^31 as unsigned, which is above any threshold
  assign mag      = corr[SW-1] ? (~corr + 1'b1) : corr;
  assign within_o = mag <= {1'b0, threshold_i};

  assign prod = PW'(corr) * $signed({{(PW - gbe_pkg::CoefW){1'b0}}, coef_i});
  // floor shift; the product never needs more than AW bits after it
  assign inc  = prod[gbe_pkg::ProdShift +: AW];
  assign sum  = {acc_q[AW-1], acc_q} + {inc[AW-1], inc};

  always_comb begin
    if (sum[AW] != sum[AW-1]) begin
      sum_sat = sum[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
    end else begin
      sum_sat = sum[AW-1:0];
    end
  end

  always_comb begin
    acc_d = acc_q;
    if (take_i && status_i.adapt) begin
      acc_d = sum_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign corrected_o = corr;
  assign offset_o    = acc_d[AW-1:gbe_pkg::AccFracW];

endmodule

// ----- rtl/core/gbe_merge.sv -----
// ----------------------------------------------------------------------------
// gbe_merge
// Combines the per-lane threshold results, keeps the stationary counter and
// decides whether this beat adapts the offsets.
// ----------------------------------------------------------------------------
module gbe_merge (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                take_i,
  input  logic [gbe_pkg::NumAxes-1:0]         within_i,
  input  logic [gbe_pkg::TimeoutW-1:0]        timeout_i,
  output gbe_pkg::status_t                    status_o
);

  logic [gbe_pkg::TimeoutW-1:0] still_cnt_q, still_cnt_d;
  logic                         below;

  assign below          = still_cnt_q < timeout_i;
  assign status_o.still = &within_i;
  assign status_o.adapt = status_o.still && !below;

  always_comb begin
    still_cnt_d = still_cnt_q;
    if (take_i) begin
      if (!status_o.still) begin
        still_cnt_d = '0;
      end else if (below) begin
        still_cnt_d = still_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      still_cnt_q <= '0;
    end else begin
      still_cnt_q <= still_cnt_d;
    end
  end

endmodule

// ----- rtl/core/gyro_bias_estimator.sv -----
// ----------------------------------------------------------------------------
// gyro_bias_estimator
// Three-axis gyro offset removal with stationary detection and slow
// high-pass adaptation of the per-axis offsets.
//
//   channel  dir  payload            handshake
//   in       in   gbe_pkg::in_t      in_valid_i / in_stall_o
//   out      out  gbe_pkg::out_t     out_valid_o / out_stall_i
//   cfg      in   31-bit data, idx   cfg_we_i, no wait
//
// One beat per cycle. A sample is processed in the cycle it is accepted and
// its result sits in the output register from the next cycle on; the loop
// through the offset accumulators (subtract, multiply, add) sets the cycle.
// The input stalls only while a result is held and the output is stalled.
// Reset clears offsets, the stationary count and the output register and
// loads the register defaults.
// ----------------------------------------------------------------------------
module gyro_bias_estimator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  gbe_pkg::in_t                      in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output gbe_pkg::out_t                     out_data_o,
  input  logic                              cfg_we_i,
  input  logic [gbe_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [gbe_pkg::CfgDataW-1:0]      cfg_wdata_i
);

  localparam int unsigned NA = gbe_pkg::NumAxes;
  localparam int unsigned SW = gbe_pkg::SampleW;

  logic [gbe_pkg::ThreshW-1:0]  threshold_q;
  logic [gbe_pkg::TimeoutW-1:0] timeout_q;
  logic [gbe_pkg::CoefW-1:0]    coef_q;

  logic                         take;
  logic                         out_valid_q;
  gbe_pkg::out_t                out_q, out_d;
  gbe_pkg::status_t             status;
  logic [NA-1:0]                lane_still;
  logic signed [SW-1:0]         gyro   [NA];
  logic signed [SW-1:0]         corr   [NA];
  logic signed [SW-1:0]         offset [NA];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= gbe_pkg::ThresholdRst;
      timeout_q   <= gbe_pkg::TimeoutRst;
      coef_q      <= gbe_pkg::CoefRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gbe_pkg::RegThreshold: threshold_q <= cfg_wdata_i[gbe_pkg::ThreshW-1:0];
        gbe_pkg::RegTimeout:   timeout_q   <= cfg_wdata_i[gbe_pkg::TimeoutW-1:0];
        gbe_pkg::RegCoef:      coef_q      <= cfg_wdata_i[gbe_pkg::CoefW-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  assign in_stall_o = out_valid_q && out_stall_i;
  assign take       = in_valid_i && !in_stall_o;

  assign gyro[0] = in_data_i.gyro_x;
  assign gyro[1] = in_data_i.gyro_y;
  assign gyro[2] = in_data_i.gyro_z;

  for (genvar a = 0; a < NA; a++) begin : g_lane
    gbe_lane u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .take_i      (take),
      .gyro_i      (gyro[a]),
      .threshold_i (threshold_q),
      .coef_i      (coef_q),
      .status_i    (status),
      .within_o    (lane_still[a]),
      .corrected_o (corr[a]),
      .offset_o    (offset[a])
    );
  end

  gbe_merge u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (take),
    .within_i  (lane_still),
    .timeout_i (timeout_q),
    .status_o  (status)
  );

  always_comb begin
    out_d.corrected_x   = corr[0];
    out_d.corrected_y   = corr[1];
    out_d.corrected_z   = corr[2];
    out_d.offset_out_x  = offset[0];
    out_d.offset_out_y  = offset[1];
    out_d.offset_out_z  = offset[2];
    out_d.is_stationary = status.still;
    out_d.is_adapting   = status.adapt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // hold the result while stalled, load on every accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else if (take) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/core/gbe_checker.sv -----
// ----------------------------------------------------------------------------
// gbe_checker
// Port-level checks for the gyro bias estimator, bound to the top level.
// ----------------------------------------------------------------------------
module gbe_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input gbe_pkg::out_t out_data_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output beat changed");

  // every accepted sample shows a result on the next cycle
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted sample produced no result");

  // input only stalls behind a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");

  // adaptation only ever happens on a stationary sample
  a_adapt_still: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.is_adapting |-> out_data_o.is_stationary)
    else $error("adapting on a moving sample");

endmodule

bind gyro_bias_estimator gbe_checker u_gbe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ----- test/tb_gyro_bias_estimator.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gyro_bias_estimator
// Self-checking bench for the gyro bias estimator. A directed table covers
// the threshold edge, saturation, register masking, a lowered timeout and a
// zero timeout. Random phases under changing register settings follow, with
// samples mostly placed around the tracked offsets so that the block goes
// still and adapts. Result beats are held to a bit-true predictor of the
// offset loop or a literal row. Input bursts and output stalls are random.
// ----------------------------------------------------------------------------
module tb_gyro_bias_estimator;
  import gbe_pkg::*;

  localparam logic [CfgIdxW-1:0]  RegUnused = 2'd3;
  localparam logic signed [31:0]  RateMax   = 32'sh7FFF_FFFF;
  localparam logic signed [31:0]  RateMin   = 32'sh8000_0000;
  localparam logic signed [63:0]  S32Max    = 64'sd2147483647;
  localparam logic signed [63:0]  S32Min    = -64'sd2147483648;
  localparam logic signed [63:0]  AccMax    = 64'sd140737488355327;
  localparam logic signed [63:0]  AccMin    = -64'sd140737488355328;
  localparam int                  NumPhases = 8;
  localparam int                  PhaseLen  = 120;

  typedef enum logic [1:0] {RowSample, RowLiteral, RowWrite} row_kind_e;
  typedef enum logic [1:0] {StallNone, StallSparse, StallHeavy, StallBursty} stall_mode_e;

  typedef struct {
    row_kind_e            kind;
    logic [CfgIdxW-1:0]   idx;
    logic [CfgDataW-1:0]  wdata;
    in_t                  smp;
    out_t                 want;
  } row_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  in_t                  in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_t                 out_data_o;
  logic                 cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i   = '0;
  logic [CfgDataW-1:0]  cfg_wdata_i = '0;

  // tracked copy of the block state and registers
  logic signed [AccW-1:0]  bias_acc [NumAxes];
  logic [TimeoutW-1:0]     still_cnt = '0;
  logic [ThreshW-1:0]      thr_reg   = ThresholdRst;
  logic [TimeoutW-1:0]     tmo_reg   = TimeoutRst;
  logic [CoefW-1:0]        coef_reg  = CoefRst;

  out_t  pending_results [$];
  row_t  directed_rows [$];

  int unsigned burst_left   = 0;
  int unsigned gap_len      = 0;
  int unsigned samples_sent = 0;
  int unsigned results_seen = 0;
  int unsigned reg_writes   = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned still_hits   = 0;
  int unsigned adapt_hits   = 0;
  int unsigned sat_hits     = 0;

  stall_mode_e stall_mode = StallNone;
  int unsigned stall_run  = 0;

  gyro_bias_estimator u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #5_000_000;
    $display("gyro_bias_estimator: mismatch");
    $finish;
  end

  // Subtract offsets, detect stillness, adapt; returns the result beat.
  function automatic out_t correct_and_track(in_t smp);
    logic signed [63:0] rate [NumAxes];
    logic signed [63:0] corr [NumAxes];
    logic signed [63:0] offs [NumAxes];
    logic signed [63:0] mag, prod, sum;
    logic still;
    logic adapt;
    out_t r;
    rate[0] = smp.gyro_x;
    rate[1] = smp.gyro_y;
    rate[2] = smp.gyro_z;
    still = 1'b1;
    adapt = 1'b0;
    for (int a = 0; a < NumAxes; a++) begin
      offs[a] = bias_acc[a] >>> AccFracW;
      corr[a] = rate[a] - offs[a];
      if (corr[a] > S32Max) begin
        corr[a] = S32Max;
        sat_hits++;
      end else if (corr[a] < S32Min) begin
        corr[a] = S32Min;
        sat_hits++;
      end
      mag = (corr[a] < 0) ? -corr[a] : corr[a];
      if (mag > 64'(thr_reg)) still = 1'b0;
    end
    if (!still) begin
      still_cnt = '0;
    end else if (still_cnt < tmo_reg) begin
      still_cnt = still_cnt + 1'b1;
    end else begin
      adapt = 1'b1;
      for (int a = 0; a < NumAxes; a++) begin
        prod = corr[a] * $signed({40'd0, coef_reg});
        sum  = bias_acc[a] + (prod >>> ProdShift);
        if (sum > AccMax) sum = AccMax;
        else if (sum < AccMin) sum = AccMin;
        bias_acc[a] = sum[AccW-1:0];
      end
    end
    for (int a = 0; a < NumAxes; a++) offs[a] = bias_acc[a] >>> AccFracW;
    if (still) still_hits++;
    if (adapt) adapt_hits++;
    r.corrected_x   = corr[0][31:0];
    r.corrected_y   = corr[1][31:0];
    r.corrected_z   = corr[2][31:0];
    r.offset_out_x  = offs[0][31:0];
    r.offset_out_y  = offs[1][31:0];
    r.offset_out_z  = offs[2][31:0];
    r.is_stationary = still;
    r.is_adapting   = adapt;
    return r;
  endfunction

  function automatic row_t sample_row(logic signed [31:0] x, y, z);
    row_t r;
    r.kind  = RowSample;
    r.idx   = '0;
    r.wdata = '0;
    r.smp   = '{x, y, z};
    r.want  = '0;
    return r;
  endfunction

  // Offsets still zero and nothing adapting: the result reads off the input.
  function automatic row_t literal_row(logic signed [31:0] x, y, z, logic st);
    row_t r;
    r.kind  = RowLiteral;
    r.idx   = '0;
    r.wdata = '0;
    r.smp   = '{x, y, z};
    r.want  = '{x, y, z, 32'sd0, 32'sd0, 32'sd0, st, 1'b0};
    return r;
  endfunction

  function automatic row_t write_row(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    row_t r;
    r.kind  = RowWrite;
    r.idx   = idx;
    r.wdata = data;
    r.smp   = '0;
    r.want  = '0;
    return r;
  endfunction

  // Drop valid and hold until every result beat has come back.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      RegThreshold: thr_reg  = data[ThreshW-1:0];
      RegTimeout:   tmo_reg  = data[TimeoutW-1:0];
      RegCoef:      coef_reg = data[CoefW-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic send_sample(in_t smp, bit use_lit, out_t lit);
    out_t pred;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap_len    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap_len != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap_len) @(negedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_data_i  <= smp;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = correct_and_track(smp);
    pending_results.push_back(use_lit ? lit : pred);
    samples_sent++;
    burst_left--;
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (stall_run == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_run  = $urandom_range(16, 96);
    end
    stall_run--;
    case (stall_mode)
      StallNone:   out_stall_i <= 1'b0;
      StallSparse: out_stall_i <= ($urandom_range(0, 3) == 0);
      StallHeavy:  out_stall_i <= ($urandom_range(0, 3) != 0);
      default:     out_stall_i <= ((stall_run % 8) < 5);
    endcase
  end

  always @(posedge clk_i) begin : result_check
    out_t want;
    logic bad;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("beat %0d: result with no sample outstanding", results_seen);
      end else begin
        want = pending_results.pop_front();
        bad  = (out_data_o.corrected_x   !== want.corrected_x)   ||
               (out_data_o.corrected_y   !== want.corrected_y)   ||
               (out_data_o.corrected_z   !== want.corrected_z)   ||
               (out_data_o.offset_out_x  !== want.offset_out_x)  ||
               (out_data_o.offset_out_y  !== want.offset_out_y)  ||
               (out_data_o.offset_out_z  !== want.offset_out_z)  ||
               (out_data_o.is_stationary !== want.is_stationary) ||
               (out_data_o.is_adapting   !== want.is_adapting);
        if (bad) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("beat %0d want: corr %0d %0d %0d off %0d %0d %0d still %0b adapt %0b",
                     results_seen, want.corrected_x, want.corrected_y, want.corrected_z,
                     want.offset_out_x, want.offset_out_y, want.offset_out_z,
                     want.is_stationary, want.is_adapting);
            $display("beat %0d got:  corr %0d %0d %0d off %0d %0d %0d still %0b adapt %0b",
                     results_seen, out_data_o.corrected_x, out_data_o.corrected_y,
                     out_data_o.corrected_z, out_data_o.offset_out_x,
                     out_data_o.offset_out_y, out_data_o.offset_out_z,
                     out_data_o.is_stationary, out_data_o.is_adapting);
          end
        end
      end
    end
  end

  initial begin : stimulus
    logic signed [31:0] ax [NumAxes];
    logic signed [63:0] off_v, noise_v, val_v;
    logic [ThreshW-1:0]  thr_v;
    logic [TimeoutW-1:0] tmo_v;
    logic [CoefW-1:0]    coef_v;
    bit wild;

    for (int a = 0; a < NumAxes; a++) bias_acc[a] = '0;

    // reset settings, zero offsets
    directed_rows.push_back(literal_row(0, 0, 0, 1'b1));
    // magnitude on the threshold still counts as stationary
    directed_rows.push_back(literal_row(32'sd196608, -32'sd196608, 0, 1'b1));
    directed_rows.push_back(literal_row(32'sd196609, 0, 0, 1'b0));
    directed_rows.push_back(literal_row(0, -32'sd196609, 32'sd7, 1'b0));
    directed_rows.push_back(literal_row(RateMax, RateMin, 0, 1'b0));
    directed_rows.push_back(literal_row(RateMin, RateMax, -32'sd1, 1'b0));
    // short timeout; upper data bits must be dropped
    directed_rows.push_back(write_row(RegThreshold, 31'd65536));
    directed_rows.push_back(write_row(RegTimeout, 31'h1234_000A));
    directed_rows.push_back(write_row(RegCoef, 31'h7F10_0000));
    directed_rows.push_back(sample_row(32'sd1000, -32'sd2000, 32'sd65536));
    directed_rows.push_back(sample_row(-32'sd65536, 32'sd65536, 0));
    directed_rows.push_back(sample_row(0, 0, 0));
    directed_rows.push_back(sample_row(32'sd65535, -32'sd65535, 32'sd1));
    directed_rows.push_back(sample_row(32'sd12, 32'sd34, 32'sd56));
    directed_rows.push_back(sample_row(-32'sd1, -32'sd1, -32'sd1));
    directed_rows.push_back(sample_row(32'sd65536, -32'sd65536, 32'sd65536));
    // timeout dropped below the running count: adapt on the next still beat
    directed_rows.push_back(write_row(RegTimeout, 31'd3));
    directed_rows.push_back(sample_row(32'sd5000, -32'sd5000, 32'sd100));
    directed_rows.push_back(sample_row(-32'sd3000, 32'sd2500, 32'sd65536));
    directed_rows.push_back(sample_row(0, 0, 32'sd200000));
    // widest threshold, full gain, zero timeout
    directed_rows.push_back(write_row(RegThreshold, 31'h7FFF_FFFF));
    directed_rows.push_back(write_row(RegCoef, 31'h7FFF_FFFF));
    directed_rows.push_back(write_row(RegTimeout, 31'h7FFF_0000));
    directed_rows.push_back(sample_row(RateMax, -RateMax, 32'sd12345));
    directed_rows.push_back(sample_row(RateMin, RateMin, RateMin));
    directed_rows.push_back(sample_row(RateMax, RateMax, RateMax));
    directed_rows.push_back(sample_row(0, 0, 0));
    directed_rows.push_back(sample_row(-32'sd1, -32'sd1, -32'sd1));
    // an index past the register list changes nothing
    directed_rows.push_back(write_row(RegUnused, 31'h0000_0005));
    directed_rows.push_back(sample_row(32'sd1, 32'sd2, 32'sd3));

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        RowWrite:   write_reg(directed_rows[i].idx, directed_rows[i].wdata);
        RowLiteral: send_sample(directed_rows[i].smp, 1'b1, directed_rows[i].want);
        default:    send_sample(directed_rows[i].smp, 1'b0, '0);
      endcase
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      if (ph == 0) begin
        thr_v  = '1;
        tmo_v  = '0;
        coef_v = '1;
      end else if (ph == 1) begin
        thr_v  = '0;
        tmo_v  = '1;
        coef_v = '0;
      end else begin
        thr_v  = $urandom_range(0, 1) ? ThreshW'($urandom_range(0, 'h80000))
                                      : ThreshW'($urandom);
        tmo_v  = ($urandom_range(0, 3) == 0) ? TimeoutW'($urandom)
                                             : TimeoutW'($urandom_range(0, 40));
        case ($urandom_range(0, 2))
          0:       coef_v = '1;
          1:       coef_v = CoefW'($urandom_range(0, 'h10000));
          default: coef_v = CoefW'($urandom);
        endcase
      end
      write_reg(RegThreshold, thr_v);
      write_reg(RegTimeout, {15'($urandom), tmo_v});
      write_reg(RegCoef, {7'($urandom), coef_v});
      if (ph >= 2 && $urandom_range(0, 1)) write_reg(RegUnused, 31'($urandom));

      repeat (PhaseLen) begin
        // most beats sit within the threshold of the tracked offsets
        wild = ($urandom_range(0, 9) < 3);
        for (int a = 0; a < NumAxes; a++) begin
          off_v = bias_acc[a] >>> AccFracW;
          if (wild && $urandom_range(0, 2) == 0) begin
            if ($urandom_range(0, 1)) begin
              val_v = $signed(32'($urandom));
            end else begin
              noise_v = 64'(thr_reg) + 1;
              val_v   = $urandom_range(0, 1) ? off_v + noise_v : off_v - noise_v;
            end
          end else begin
            case ($urandom_range(0, 3))
              0:       noise_v = 0;
              1:       noise_v = 64'(thr_reg);
              default: noise_v = 64'($urandom) % (64'(thr_reg) + 1);
            endcase
            val_v = $urandom_range(0, 1) ? off_v + noise_v : off_v - noise_v;
          end
          if (val_v > S32Max) val_v = S32Max;
          else if (val_v < S32Min) val_v = S32Min;
          ax[a] = val_v[31:0];
        end
        send_sample('{ax[0], ax[1], ax[2]}, 1'b0, '0);
      end
    end

    settle();
    repeat (8) @(negedge clk_i);

    $display("%0d samples (%0d table rows), %0d result beats, %0d register writes",
             samples_sent, directed_rows.size(), results_seen, reg_writes);
    $display("%0d stationary, %0d adapting, %0d saturated corrections, %0d bad beats",
             still_hits, adapt_hits, sat_hits, mismatch_cnt);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("gyro_bias_estimator: match");
    end else begin
      $display("gyro_bias_estimator: mismatch");
    end
    $finish;
  end

endmodule

// ----- gyro_bias_estimator.f -----
rtl/core/gbe_pkg.sv
rtl/core/gbe_lane.sv
rtl/core/gbe_merge.sv
rtl/core/gyro_bias_estimator.sv
rtl/core/gbe_checker.sv
test/tb_gyro_bias_estimator.sv
